/* hw/rtl/jswp_pkg.sv */
// Shared types and constants for the JTAG shift word packer.
// No dependencies; imported by every module of the block.
package jswp_pkg;

	localparam int CHUNK_WORDS_DEF = 4;
	localparam int QUEUE_DEPTH     = 2;

	// Input operation codes (carried on s_tuser)
	localparam logic OP_BIT = 1'b0;
	localparam logic OP_RX  = 1'b1;

	// Result kinds (carried on m_tuser)
	localparam logic KIND_CMD = 1'b0;
	localparam logic KIND_TDO = 1'b1;

	// Field bases inside a command word
	localparam int TDI_BASE  = 0;
	localparam int TCK_BASE  = 8;
	localparam int READ_BASE = 12;

	// One job handed from the front to the back
	typedef struct packed {
		logic        is_tdo;   // unpack a returned word
		logic [15:0] data;     // command word, or returned TDO word
		logic [3:0]  n_bits;   // TDO bits to unpack
		logic        extra;    // a zero dummy word follows and closes the chunk
		logic        close;    // last word of this job closes a chunk
		logic [3:0]  changes;  // chunk change count on close
		logic [3:0]  reads;    // chunk read count on close
	} job_t;

endpackage

/* hw/rtl/jswp_front.sv */
// Front end: accepts requests, packs TDI bits into words, tracks chunk state.
// Depends on jswp_pkg; produces job_t entries for the queue.
module jswp_front #(
	parameter int CHUNK_WORDS = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          op,
	input  logic          tdi_bit,
	input  logic          capture,
	input  logic          final_bit,
	input  logic [15:0]   rx_word,
	input  logic          q_full,
	output logic          push,
	output jswp_pkg::job_t push_job
);
	import jswp_pkg::*;

	localparam logic [3:0] CLOSE_AT = 4'(4 * CHUNK_WORDS - 1);

	logic [3:0]  change_count_q;
	logic [3:0]  read_count_q;
	logic [15:0] work_word_q;
	logic [3:0]  pending_reads_q;

	logic        accept;
	logic [1:0]  pos;
	logic [15:0] base_word;
	logic [15:0] new_word;
	logic [3:0]  new_changes;
	logic [3:0]  new_reads;
	logic        closing;
	logic        word_full;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		pos         = change_count_q[1:0];
		base_word   = (pos == 2'd0) ? 16'd0 : work_word_q;
		new_word    = base_word
		            | (16'(tdi_bit) << (TDI_BASE + 32'(pos)))
		            | (16'd1 << (TCK_BASE + 32'(pos)))
		            | (16'(capture) << (READ_BASE + 32'(pos)));
		new_changes = change_count_q + 4'd1;
		new_reads   = read_count_q + 4'(capture);
		word_full   = (new_changes[1:0] == 2'd0);
		closing     = (new_changes == CLOSE_AT) || final_bit;

		push     = 1'b0;
		push_job = '0;
		if (accept) begin
			if (op == OP_BIT) begin
				push_job.data = new_word;
				if (new_changes == CLOSE_AT) begin
					push             = 1'b1;
					push_job.close   = 1'b1;
					push_job.changes = new_changes;
					push_job.reads   = new_reads;
				end else if (final_bit) begin
					// full word on the final bit: add a non-clocking dummy change
					push             = 1'b1;
					push_job.close   = 1'b1;
					push_job.extra   = word_full;
					push_job.changes = word_full ? (new_changes + 4'd1) : new_changes;
					push_job.reads   = new_reads;
				end else if (word_full) begin
					push = 1'b1;
				end
			end else if (pending_reads_q != 4'd0) begin
				push            = 1'b1;
				push_job.is_tdo = 1'b1;
				push_job.data   = rx_word;
				push_job.n_bits = pending_reads_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			change_count_q  <= '0;
			read_count_q    <= '0;
			work_word_q     <= '0;
			pending_reads_q <= '0;
		end else if (accept) begin
			if (op == OP_BIT) begin
				if (closing) begin
					change_count_q  <= '0;
					read_count_q    <= '0;
					work_word_q     <= '0;
					pending_reads_q <= new_reads;
				end else begin
					change_count_q <= new_changes;
					read_count_q   <= new_reads;
					work_word_q    <= new_word;
				end
			end else begin
				pending_reads_q <= '0;
			end
		end
	end

endmodule

/* hw/rtl/jswp_queue.sv */
// Short job queue between front and back ends.
// Depends on jswp_pkg for job_t and QUEUE_DEPTH.
module jswp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  jswp_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output jswp_pkg::job_t head_job
);
	import jswp_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	job_t          slots_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = slots_q[rd_ptr_q];

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* hw/rtl/jswp_back.sv */
// Back end: expands jobs into registered results, one per cycle unless output stalls.
// Depends on jswp_pkg for job_t and result kind codes.
module jswp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  jswp_pkg::job_t head_job,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           kind,
	output logic [15:0]    cmd_word,
	output logic           chunk_end,
	output logic [3:0]     chunk_changes,
	output logic [3:0]     chunk_reads,
	output logic           tdo_bit,
	output logic           last
);
	import jswp_pkg::*;

	logic [3:0]  step_q;
	logic        out_valid_q;
	logic        kind_q;
	logic [15:0] cmd_word_q;
	logic        chunk_end_q;
	logic [3:0]  chunk_changes_q;
	logic [3:0]  chunk_reads_q;
	logic        tdo_bit_q;
	logic        last_q;

	logic        load;
	logic        r_kind;
	logic [15:0] r_word;
	logic        r_end;
	logic [3:0]  r_changes;
	logic [3:0]  r_reads;
	logic        r_tdo;
	logic        r_last;
	logic [4:0]  bit_idx;

	assign load = head_valid && (!out_valid_q || out_ready);
	assign pop  = load && r_last;

	always_comb begin
		// MSB-aligned: bit k of n comes from position 16-n+k
		bit_idx   = 5'd16 - {1'b0, head_job.n_bits} + {1'b0, step_q};
		r_kind    = KIND_CMD;
		r_word    = '0;
		r_end     = 1'b0;
		r_changes = '0;
		r_reads   = '0;
		r_tdo     = 1'b0;
		r_last    = 1'b1;
		if (head_job.is_tdo) begin
			r_kind = KIND_TDO;
			r_tdo  = head_job.data[bit_idx[3:0]];
			r_last = (step_q == head_job.n_bits - 4'd1);
		end else if (head_job.extra && step_q == 4'd0) begin
			r_word = head_job.data;
			r_last = 1'b0;
		end else begin
			// dummy word is all zero; otherwise the job's own word
			r_word    = head_job.extra ? 16'd0 : head_job.data;
			r_end     = head_job.close;
			r_changes = head_job.close ? head_job.changes : 4'd0;
			r_reads   = head_job.close ? head_job.reads : 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				step_q      <= r_last ? 4'd0 : step_q + 4'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q          <= r_kind;
			cmd_word_q      <= r_word;
			chunk_end_q     <= r_end;
			chunk_changes_q <= r_changes;
			chunk_reads_q   <= r_reads;
			tdo_bit_q       <= r_tdo;
			last_q          <= r_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign cmd_word      = cmd_word_q;
	assign chunk_end     = chunk_end_q;
	assign chunk_changes = chunk_changes_q;
	assign chunk_reads   = chunk_reads_q;
	assign tdo_bit       = tdo_bit_q;
	assign last          = last_q;

endmodule

/* hw/rtl/jtag_shift_word_packer.sv */
// Top level of the JTAG shift word packer: front end, job queue, back end.
// Depends on jswp_pkg, jswp_front, jswp_queue and jswp_back.
//
//  Channel | Direction | tuser | tlast     | tdata (low bit first)
//  --------+-----------+-------+-----------+---------------------------------------------
//  s_*     | in        | op    | final_bit | tdi_bit, capture, rx_word, pad to 24 bits
//  m_*     | out       | kind  | last      | cmd_word, chunk_end, chunk_changes,
//          |           |       |           | chunk_reads, tdo_bit, pad to 32 bits
//
// A request is taken whenever the two-entry job queue has room.
// The back end emits one result per cycle unless m_tready stalls it: a TDI bit
// request yields zero, one or two command words; a returned TDO word yields one
// result per pending bit, up to 15 results, which sets the sustained rate for unpack requests.
// The output register decouples m_tready stalls; the queue lets the front keep
// accepting while the back is busy. Asynchronous reset clears all chunk state.
module jtag_shift_word_packer #(
	parameter int CHUNK_WORDS = jswp_pkg::CHUNK_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [0] tdi_bit, [1] capture, [17:2] rx_word, rest zero
	input  logic        s_tuser,   // op
	input  logic        s_tlast,   // final_bit
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] cmd_word, [16] chunk_end, [20:17] chunk_changes,
	                               // [24:21] chunk_reads, [25] tdo_bit, rest zero
	output logic        m_tuser,   // kind
	output logic        m_tlast    // last
);
	import jswp_pkg::*;

	job_t        push_job;
	job_t        head_job;
	logic        push;
	logic        q_full;
	logic        head_valid;
	logic        pop;
	logic [15:0] cmd_word;
	logic        chunk_end;
	logic [3:0]  chunk_changes;
	logic [3:0]  chunk_reads;
	logic        tdo_bit;

	jswp_front #(
		.CHUNK_WORDS(CHUNK_WORDS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.op        (s_tuser),
		.tdi_bit   (s_tdata[0]),
		.capture   (s_tdata[1]),
		.final_bit (s_tlast),
		.rx_word   (s_tdata[17:2]),
		.q_full    (q_full),
		.push      (push),
		.push_job  (push_job)
	);

	jswp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	jswp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_job      (head_job),
		.pop           (pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.kind          (m_tuser),
		.cmd_word      (cmd_word),
		.chunk_end     (chunk_end),
		.chunk_changes (chunk_changes),
		.chunk_reads   (chunk_reads),
		.tdo_bit       (tdo_bit),
		.last          (m_tlast)
	);

	// result fields packed from bit 0 up, zero padded to a whole byte
	assign m_tdata = {6'd0, tdo_bit, chunk_reads, chunk_changes, chunk_end, cmd_word};

endmodule

/* verif/tb_jtag_shift_word_packer.sv */
// Self-checking testbench for jtag_shift_word_packer: directed and random TDI bit and
// TDO word requests, with a mirror of the chunk state predicting every output request.
// Depends on jswp_pkg and the jtag_shift_word_packer RTL.
module tb_jtag_shift_word_packer;
	import jswp_pkg::*;

	localparam int CHUNK_WORDS = CHUNK_WORDS_DEF;
	localparam int RAND_REQS   = 230;
	localparam int HOLD_AT     = 30;      // requests taken before the long output hold-off
	localparam int HOLD_LEN    = 300;     // cycles of that hold-off
	localparam int DRAIN       = 20;      // quiet cycles after the last result
	localparam int LIMIT_CYC   = 400000;

	typedef enum int {MIX_NONE, MIX_SRC, MIX_SINK, MIX_BOTH} idle_mix_t;

	typedef struct packed {
		logic        op;
		logic        tdi;
		logic        cap;
		logic        fin;
		logic [15:0] rx;
	} req_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] cmd_word;
		logic        chunk_end;
		logic [3:0]  chunk_changes;
		logic [3:0]  chunk_reads;
		logic        tdo_bit;
		logic        last;
	} out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	jtag_shift_word_packer #(.CHUNK_WORDS(CHUNK_WORDS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #6 clk = ~clk;

	req_t shift_reqs[$];    // requests still to be offered
	out_t pending_out[$];   // results the block still owes, oldest first
	req_t offered;
	int   total_reqs = 1;
	int   reqs_taken = 0;
	int   hold_cycles = 0;
	int   errors = 0;
	int   n_words = 0;
	int   n_closes = 0;
	int   n_tdo = 0;
	wire  holding = (reqs_taken >= HOLD_AT) && (hold_cycles != HOLD_LEN);

	// Mirror of the packer's chunk state
	logic [3:0]  chg_cnt = '0;
	logic [3:0]  rd_cnt = '0;
	logic [15:0] fill_word = '0;
	logic [3:0]  tdo_owed = '0;

	function automatic out_t cmd_out(logic [15:0] w, logic seals);
		out_t r;
		r = '0;
		r.kind = KIND_CMD;
		r.cmd_word = w;
		r.chunk_end = seals;
		if (seals) begin
			r.chunk_changes = chg_cnt;
			r.chunk_reads = rd_cnt;
		end
		return r;
	endfunction

	function automatic out_t seal_chunk();
		out_t r;
		r = cmd_out(fill_word, 1'b1);
		tdo_owed = rd_cnt;
		chg_cnt = '0;
		rd_cnt = '0;
		fill_word = '0;
		return r;
	endfunction

	function automatic void clock_change(logic tdi, logic cap, logic toggles);
		int p;
		p = int'(chg_cnt[1:0]);
		if (p == 0)
			fill_word = '0;
		chg_cnt = chg_cnt + 4'd1;
		if (toggles) begin
			if (tdi)
				fill_word[TDI_BASE + p] = 1'b1;
			fill_word[TCK_BASE + p] = 1'b1;
			if (cap) begin
				fill_word[READ_BASE + p] = 1'b1;
				rd_cnt = rd_cnt + 4'd1;
			end
		end
	endfunction

	// Apply one accepted request to the mirror and queue the results it owes
	task automatic shift_request(req_t rq);
		out_t outs[$];
		out_t r;
		int   n;
		int   k;
		if (rq.op == OP_BIT) begin
			clock_change(rq.tdi, rq.cap, 1'b1);
			if (chg_cnt == 4 * CHUNK_WORDS - 1) begin
				// chunk full: this close is also the flush, no pad change
				outs.push_back(seal_chunk());
			end else begin
				if (chg_cnt[1:0] == 2'd0)
					outs.push_back(cmd_out(fill_word, 1'b0));
				if (rq.fin && chg_cnt != 0) begin
					// word boundary on the final bit: pad with a non-clocking change
					if (chg_cnt[1:0] == 2'd0)
						clock_change(1'b0, 1'b0, 1'b0);
					outs.push_back(seal_chunk());
				end
			end
		end else begin
			// unpack MSB-aligned; nothing owed means nothing comes out
			n = int'(tdo_owed);
			for (k = 0; k < n; k++) begin
				r = '0;
				r.kind = KIND_TDO;
				r.tdo_bit = rq.rx[16 - n + k];
				outs.push_back(r);
			end
			tdo_owed = '0;
		end
		for (k = 0; k < outs.size(); k++) begin
			r = outs[k];
			r.last = (k == outs.size() - 1);
			pending_out.push_back(r);
		end
	endtask

	function automatic req_t bit_req(logic tdi, logic cap, logic fin);
		req_t r;
		r.op = OP_BIT;
		r.tdi = tdi;
		r.cap = cap;
		r.fin = fin;
		r.rx = 16'($urandom);    // ignored for bit requests
		return r;
	endfunction

	function automatic req_t rx_req(logic [15:0] rx);
		req_t r;
		r.op = OP_RX;
		r.tdi = 1'($urandom_range(1));
		r.cap = 1'($urandom_range(1));
		r.fin = 1'($urandom_range(1));
		r.rx = rx;
		return r;
	endfunction

	function automatic idle_mix_t idle_mix();
		int q;
		q = (reqs_taken * 4) / total_reqs;
		if (q > 3)
			q = 3;
		return idle_mix_t'(q);
	endfunction

	function automatic logic src_rests();
		case (idle_mix())
			MIX_SRC:  return $urandom_range(99) < 81;
			MIX_BOTH: return $urandom_range(99) < 11;
			default:  return 1'b0;
		endcase
	endfunction

	function automatic logic sink_stalls();
		case (idle_mix())
			MIX_SINK: return $urandom_range(99) < 81;
			MIX_BOTH: return $urandom_range(99) < 11;
			default:  return 1'b0;
		endcase
	endfunction

	function automatic string show(out_t r);
		return $sformatf("kind=%0d word=%h end=%0d chg=%0d rd=%0d tdo=%0d last=%0d",
			r.kind, r.cmd_word, r.chunk_end, r.chunk_changes, r.chunk_reads,
			r.tdo_bit, r.last);
	endfunction

	// Input side: offer queued requests, predict each one as it is taken
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				shift_request(offered);
				reqs_taken <= reqs_taken + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (shift_reqs.size() != 0 && !src_rests()) begin
					offered = shift_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {6'd0, offered.rx, offered.cap, offered.tdi};
					s_tuser <= offered.op;
					s_tlast <= offered.fin;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// One long output hold-off so the job queue fills and input backs up
	always @(posedge clk) begin
		if (!arst_n)
			hold_cycles <= 0;
		else if (holding)
			hold_cycles <= hold_cycles + 1;
	end

	// Output side: check every result against the oldest owed one
	always @(posedge clk) begin
		out_t got;
		out_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.kind = m_tuser;
				got.cmd_word = m_tdata[15:0];
				got.chunk_end = m_tdata[16];
				got.chunk_changes = m_tdata[20:17];
				got.chunk_reads = m_tdata[24:21];
				got.tdo_bit = m_tdata[25];
				got.last = m_tlast;
				if (pending_out.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: %s", show(got));
				end else begin
					want = pending_out.pop_front();
					if (got.kind !== want.kind || got.cmd_word !== want.cmd_word ||
					    got.chunk_end !== want.chunk_end ||
					    got.chunk_changes !== want.chunk_changes ||
					    got.chunk_reads !== want.chunk_reads ||
					    got.tdo_bit !== want.tdo_bit || got.last !== want.last) begin
						errors++;
						if (errors <= 10)
							$display("mismatch\n  exp %s\n  got %s", show(want), show(got));
					end
					if (want.kind == KIND_TDO)
						n_tdo++;
					else
						n_words++;
					if (want.chunk_end)
						n_closes++;
				end
			end
			m_tready <= !holding && !sink_stalls();
		end
	end

	initial begin
		int n_rand;
		int len;
		int cap_pct;
		int pos;
		int i;
		logic fin;

		// Directed: TDO word with nothing owed
		shift_reqs.push_back(rx_req(16'hFFFF));
		// single-bit transfer, closed at once
		shift_reqs.push_back(bit_req(1'b1, 1'b1, 1'b1));
		// four bits end on a word boundary: pad change, and the owed count is replaced
		shift_reqs.push_back(bit_req(1'b1, 1'b1, 1'b0));
		shift_reqs.push_back(bit_req(1'b0, 1'b0, 1'b0));
		shift_reqs.push_back(bit_req(1'b1, 1'b1, 1'b0));
		shift_reqs.push_back(bit_req(1'b1, 1'b1, 1'b1));
		shift_reqs.push_back(rx_req(16'hFFFF));
		// full chunk of captured bits, final on the closing change
		for (i = 0; i < 4 * CHUNK_WORDS - 1; i++)
			shift_reqs.push_back(bit_req(i[0], 1'b1, i == 4 * CHUNK_WORDS - 2));
		shift_reqs.push_back(rx_req(16'h0000));

		// Random transfers, mostly well formed, each close usually followed by its TDO word
		n_rand = 0;
		pos = 0;
		while (n_rand < RAND_REQS) begin
			if ($urandom_range(99) < 8) begin
				shift_reqs.push_back(rx_req(16'($urandom)));
			end else begin
				len = ($urandom_range(5) == 0) ? $urandom_range(16, 45) : $urandom_range(1, 15);
				cap_pct = $urandom_range(100);
				for (i = 1; i <= len; i++) begin
					// now and then the final mark is missing and the transfer runs on
					fin = (i == len) && ($urandom_range(19) != 0);
					shift_reqs.push_back(bit_req(1'($urandom_range(1)),
						$urandom_range(99) < cap_pct, fin));
					n_rand++;
					pos++;
					if (pos == 4 * CHUNK_WORDS - 1 || fin) begin
						pos = 0;
						if ($urandom_range(99) < 85) begin
							shift_reqs.push_back(rx_req(16'($urandom)));
							n_rand++;
						end
					end
				end
			end
		end
		total_reqs = shift_reqs.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (shift_reqs.size() != 0 || s_tvalid || pending_out.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);

		$display("ran %0d requests: %0d command words, %0d chunk closes, %0d TDO bits",
			reqs_taken, n_words, n_closes, n_tdo);
		$display("idle mixes none/input/output/both, one %0d-cycle output hold-off, %0d errors",
			HOLD_LEN, errors);
		if (errors == 0 && pending_out.size() == 0)
			$display("tb_jtag_shift_word_packer: PASS");
		else
			$display("tb_jtag_shift_word_packer: FAIL");
		$finish;
	end

	initial begin
		#(LIMIT_CYC * 12);
		$display("timeout with %0d results still owed", pending_out.size());
		$display("tb_jtag_shift_word_packer: FAIL");
		$finish;
	end

endmodule
